// ----- hdl/bct_pkg.sv -----
// ============================================================================
// bct_pkg: shared types and constants for the box collision table
// Operation codes, sequencer states, table sizing, doubled-coordinate span
// types and the helpers that turn a center and full size into doubled values.
// ============================================================================
package bct_pkg;

    // Table sizing
    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    // Field widths
    localparam int CEN_W = 16;
    localparam int EXT_W = 15;
    // Doubled value 2c +/- e or 2c - 2e needs two more bits than a center
    localparam int PT_W  = CEN_W + 2;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef logic signed [PT_W-1:0] t_pt;

    // Stored box interval on one axis, doubled units
    typedef struct packed {
        t_pt lo;
        t_pt hi;
    } t_span;

    typedef struct packed {
        t_span x;
        t_span y;
        t_span z;
    } t_box;

    // Camera probe points, two per axis, doubled units
    typedef struct packed {
        t_pt xa;
        t_pt xb;
        t_pt ya;
        t_pt yb;
        t_pt za;
        t_pt zb;
    } t_cam;

    // 2c as an 18-bit signed value
    function automatic t_pt dbl(input logic signed [CEN_W-1:0] c);
        return t_pt'({c[CEN_W-1], c, 1'b0});
    endfunction

    // e zero-extended to 18 bits
    function automatic t_pt ext(input logic [EXT_W-1:0] e);
        return t_pt'({3'b000, e});
    endfunction

    // 2c - e
    function automatic t_pt pt_lo(input logic signed [CEN_W-1:0] c,
                                  input logic [EXT_W-1:0] e);
        return dbl(c) - ext(e);
    endfunction

    // 2c + e
    function automatic t_pt pt_hi(input logic signed [CEN_W-1:0] c,
                                  input logic [EXT_W-1:0] e);
        return dbl(c) + ext(e);
    endfunction

    // 2c - 2e
    function automatic t_pt pt_lo2(input logic signed [CEN_W-1:0] c,
                                   input logic [EXT_W-1:0] e);
        return dbl(c) - t_pt'({2'b00, e, 1'b0});
    endfunction

endpackage

// ----- hdl/bct_match.sv -----
// ============================================================================
// bct_match: shared box-versus-camera test unit
// Checks one stored box against the camera probe points on all three axes.
// An axis passes when either probe point lies inside the box interval.
// ============================================================================
module bct_match (
    input  bct_pkg::t_box i_box,
    input  bct_pkg::t_cam i_cam,
    output logic          o_match
);
    import bct_pkg::*;

    logic w_x;
    logic w_y;
    logic w_z;

    // Closed-interval containment of either probe point per axis
    always_comb begin
        w_x = ((i_box.x.lo <= i_cam.xa) && (i_cam.xa <= i_box.x.hi)) ||
              ((i_box.x.lo <= i_cam.xb) && (i_cam.xb <= i_box.x.hi));
        w_y = ((i_box.y.lo <= i_cam.ya) && (i_cam.ya <= i_box.y.hi)) ||
              ((i_box.y.lo <= i_cam.yb) && (i_cam.yb <= i_box.y.hi));
        w_z = ((i_box.z.lo <= i_cam.za) && (i_cam.za <= i_box.z.hi)) ||
              ((i_box.z.lo <= i_cam.zb) && (i_cam.zb <= i_box.z.hi));
    end

    assign o_match = w_x && w_y && w_z;

endmodule

// ----- hdl/box_collision_table.sv -----
// ============================================================================
// box_collision_table: table of axis-aligned boxes with a camera query
// Adds boxes, clears the table, or tests a camera box against every entry.
// ============================================================================
// Each accepted item yields one result, strobed by o_done for a single cycle
// and not held: the receiver must take it then. Add, clear and the unused
// operation never raise busy; their result appears the cycle after the
// transfer, so another item may follow at once. A query against N stored
// boxes walks the table through the single read port of the box memory, one
// entry per cycle, with the read and the compare overlapped: busy stays high
// until the last entry is compared or a hit is found, and busy falls in the
// same cycle as the result strobes. A query on an empty table answers like an add.
// Box intervals are stored pre-doubled, so each entry costs one compare pass.
// ============================================================================
module box_collision_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_operation,
    input  logic signed [bct_pkg::CEN_W-1:0]    i_center_x,
    input  logic signed [bct_pkg::CEN_W-1:0]    i_center_y,
    input  logic signed [bct_pkg::CEN_W-1:0]    i_center_z,
    input  logic [bct_pkg::EXT_W-1:0]           i_extent_x,
    input  logic [bct_pkg::EXT_W-1:0]           i_extent_y,
    input  logic [bct_pkg::EXT_W-1:0]           i_extent_z,
    output logic                                o_done,
    output logic                                o_hit,
    output logic                                o_dropped
);
    import bct_pkg::*;

    // State and control registers
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_rd_valid;
    logic             r_done, n_done;
    logic             r_hit, n_hit;
    logic             r_dropped, n_dropped;

    // Payload registers
    t_cam             r_cam;
    t_box             r_rd_data;
    t_box             r_mem [MAX_BOXES];

    logic             w_accept;
    t_op              w_op;
    logic             w_full;
    logic             w_empty;
    logic             w_rd_en;
    logic             w_finish;
    logic             w_match;
    t_box             w_new_box;

    assign w_op     = t_op'(i_operation);
    assign w_accept = start && (r_state == ST_IDLE);
    assign w_full   = (r_count == CNT_W'(MAX_BOXES));
    assign w_empty  = (r_count == '0);

    // Doubled interval of an incoming box
    always_comb begin
        w_new_box.x.lo = pt_lo(i_center_x, i_extent_x);
        w_new_box.x.hi = pt_hi(i_center_x, i_extent_x);
        w_new_box.y.lo = pt_lo(i_center_y, i_extent_y);
        w_new_box.y.hi = pt_hi(i_center_y, i_extent_y);
        w_new_box.z.lo = pt_lo(i_center_z, i_extent_z);
        w_new_box.z.hi = pt_hi(i_center_z, i_extent_z);
    end

    // Compare unit, reused for every entry of a scan
    bct_match u_match (
        .i_box   (r_rd_data),
        .i_cam   (r_cam),
        .o_match (w_match)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_op == OP_QUERY) && !w_empty) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer and the next result
    always_comb begin
        busy      = 1'b0;
        w_rd_en   = 1'b0;
        w_finish  = 1'b0;
        n_done    = 1'b0;
        n_hit     = 1'b0;
        n_dropped = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && !((w_op == OP_QUERY) && !w_empty)) begin
                    n_done    = 1'b1;
                    n_dropped = (w_op == OP_ADD) && w_full;
                end
            end
            ST_SCAN: begin
                busy     = 1'b1;
                w_rd_en  = (r_idx < r_count);
                w_finish = r_rd_valid && (w_match || (r_idx == r_count));
                if (w_finish) begin
                    n_done = 1'b1;
                    n_hit  = w_match;
                end
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
            r_done     <= 1'b0;
            r_hit      <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_hit      <= n_hit;
            r_dropped  <= n_dropped;
            r_rd_valid <= w_rd_en;
            if (w_accept) begin
                r_idx <= '0;
                if (w_op == OP_ADD && !w_full) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (w_op == OP_CLEAR) begin
                    r_count <= '0;
                end
            end else if (w_rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // Camera probe points, captured on a query transfer
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == OP_QUERY)) begin
            r_cam.xa <= pt_lo(i_center_x, i_extent_x);
            r_cam.xb <= pt_hi(i_center_x, i_extent_x);
            r_cam.ya <= pt_lo2(i_center_y, i_extent_y);
            r_cam.yb <= dbl(i_center_y);
            r_cam.za <= pt_lo(i_center_z, i_extent_z);
            r_cam.zb <= pt_hi(i_center_z, i_extent_z);
        end
    end

    // Box memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == OP_ADD) && !w_full) begin
            r_mem[r_count[IDX_W-1:0]] <= w_new_box;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    assign o_done    = r_done;
    assign o_hit     = r_hit;
    assign o_dropped = r_dropped;

endmodule

// ----- hdl/bct_checker.sv -----
// ============================================================================
// bct_checker: port-level checks for the box collision table
// Watches the command and result ports over time; bound to the top level.
// ============================================================================
module bct_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_done,
    input logic       o_hit,
    input logic       o_dropped
);
    import bct_pkg::*;

    // Add, clear and no-op transfers answer in the next cycle
    a_short_op_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation != OP_QUERY)) |=> o_done)
        else $error("short operation gave no result in the next cycle");

    // A query either starts a scan or answers at once
    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_QUERY)) |=> (busy || o_done))
        else $error("query neither scanning nor answered");

    // A scan only starts from a query transfer
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_operation == OP_QUERY)))
        else $error("busy raised without a query transfer");

    // A result is never shown while a scan is still running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed during a scan");

    // Flags only with a result, and never both
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit || o_dropped) |-> (o_done && !(o_hit && o_dropped)))
        else $error("result flags outside a result or both set");

endmodule

bind box_collision_table bct_checker u_bct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_done      (o_done),
    .o_hit       (o_hit),
    .o_dropped   (o_dropped)
);

// ----- tb/box_collision_table_tb.sv -----
// ============================================================================
// box_collision_table_tb: self-checking testbench for the box collision table
// Drives add, clear, query and unused-operation commands through the
// start/busy handshake. A local copy of the box table predicts hit and
// dropped for every transfer, and each strobed result is checked in order.
// ============================================================================
module box_collision_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bct_pkg::*;

    // No transfer for this many cycles means the block is stuck
    localparam int WATCHDOG_LIMIT = 4000;
    // Margin for results that strobe after the last transfer
    localparam int TAIL_CYCLES    = 4;

    typedef struct {
        logic signed [CEN_W-1:0] cx;
        logic signed [CEN_W-1:0] cy;
        logic signed [CEN_W-1:0] cz;
        logic [EXT_W-1:0]        ex;
        logic [EXT_W-1:0]        ey;
        logic [EXT_W-1:0]        ez;
    } t_box_rec;

    typedef struct {
        logic hit;
        logic dropped;
    } t_outcome;

    // Clock and DUT ports; the driven inputs are known from time zero
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic [1:0]              i_operation = OP_NOP;
    logic signed [CEN_W-1:0] i_center_x  = '0;
    logic signed [CEN_W-1:0] i_center_y  = '0;
    logic signed [CEN_W-1:0] i_center_z  = '0;
    logic [EXT_W-1:0]        i_extent_x  = '0;
    logic [EXT_W-1:0]        i_extent_y  = '0;
    logic [EXT_W-1:0]        i_extent_z  = '0;
    logic                    o_done;
    logic                    o_hit;
    logic                    o_dropped;

    // Local copy of the table and the outcomes still in flight
    t_box_rec model_boxes [MAX_BOXES];
    int       box_total = 0;
    t_outcome pending_outcomes [$];

    int sender_idle_pct = 0;
    int items_sent      = 0;
    int queries_sent    = 0;
    int hits_seen       = 0;
    int drops_seen      = 0;
    int mismatch_count  = 0;
    int idle_cycles     = 0;

    always #6 i_clk = ~i_clk;

    box_collision_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_extent_x  (i_extent_x),
        .i_extent_y  (i_extent_y),
        .i_extent_z  (i_extent_z),
        .o_done      (o_done),
        .o_hit       (o_hit),
        .o_dropped   (o_dropped)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Either probe point inside [lo, hi], all in doubled units
    function automatic logic end_inside(int lo, int hi, int pa, int pb);
        return (lo <= pa && pa <= hi) || (lo <= pb && pb <= hi);
    endfunction

    function automatic logic box_collides(t_box_rec b, t_box_rec cam);
        int bc;
        int be;
        int cc;
        int ce;
        logic ok;
        // x: camera ends at 2c -/+ e
        bc = b.cx;  be = b.ex;  cc = cam.cx;  ce = cam.ex;
        ok = end_inside(2*bc - be, 2*bc + be, 2*cc - ce, 2*cc + ce);
        // y: camera spans [c - e, c], doubled [2c - 2e, 2c]
        bc = b.cy;  be = b.ey;  cc = cam.cy;  ce = cam.ey;
        ok &= end_inside(2*bc - be, 2*bc + be, 2*cc - 2*ce, 2*cc);
        // z: same as x
        bc = b.cz;  be = b.ez;  cc = cam.cz;  ce = cam.ez;
        ok &= end_inside(2*bc - be, 2*bc + be, 2*cc - ce, 2*cc + ce);
        return ok;
    endfunction

    // Apply one command to the local table and return its outcome
    function automatic t_outcome apply_to_table(t_op op, t_box_rec b);
        t_outcome o;
        o.hit     = 1'b0;
        o.dropped = 1'b0;
        case (op)
            OP_ADD: begin
                if (box_total < MAX_BOXES) begin
                    model_boxes[box_total] = b;
                    box_total++;
                end else begin
                    o.dropped = 1'b1;
                end
            end
            OP_CLEAR: begin
                box_total = 0;
            end
            OP_QUERY: begin
                for (int i = 0; i < box_total; i++) begin
                    if (box_collides(model_boxes[i], b)) begin
                        o.hit = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Append an expected outcome behind the ones still in flight
    function automatic void enqueue_outcome(t_outcome o);
        pending_outcomes = {pending_outcomes, o};
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_box_rec mk_box(int cx, int cy, int cz, int ex, int ey, int ez);
        t_box_rec b;
        b.cx = CEN_W'(cx);
        b.cy = CEN_W'(cy);
        b.cz = CEN_W'(cz);
        b.ex = EXT_W'(ex);
        b.ey = EXT_W'(ey);
        b.ez = EXT_W'(ez);
        return b;
    endfunction

    // Half full-range boxes, half clustered near the origin so they overlap
    function automatic t_box_rec random_box();
        if ($urandom_range(1))
            return mk_box($urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom());
        return mk_box(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                      int'($urandom_range(4095)) - 2048, $urandom_range(2047),
                      $urandom_range(2047), $urandom_range(2047));
    endfunction

    // Center somewhere inside the stored interval, clamped to Q8.8 range
    function automatic int near_center(logic signed [CEN_W-1:0] c, logic [EXT_W-1:0] e);
        int v;
        int half;
        half = e;
        v = c;
        v = v + int'($urandom_range(half)) - half / 2;
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // Camera placed on a stored box, so hits are common
    function automatic t_box_rec near_camera(t_box_rec b);
        return mk_box(near_center(b.cx, b.ex), near_center(b.cy, b.ey),
                      near_center(b.cz, b.ez), $urandom_range(b.ex),
                      $urandom_range(b.ey), $urandom_range(b.ez));
    endfunction

    // Camera strictly around a stored box on x and z: a miss by the rule, unless the box extent is at its maximum
    function automatic t_box_rec enclosing_camera(t_box_rec b);
        int wx;
        int wz;
        wx = int'(b.ex) * 2 + 2 + int'($urandom_range(255));
        wz = int'(b.ez) * 2 + 2 + int'($urandom_range(255));
        if (wx > 32767) wx = 32767;
        if (wz > 32767) wz = 32767;
        return mk_box(b.cx, b.cy, b.cz, wx, b.ey, wz);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one command per call, random idle gaps before it
    // ------------------------------------------------------------------------
    task automatic send_item(input t_op op, input t_box_rec b);
        if (int'($urandom_range(99)) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while (int'($urandom_range(99)) < sender_idle_pct)
                @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_center_x  <= b.cx;
        i_center_y  <= b.cy;
        i_center_z  <= b.cz;
        i_extent_x  <= b.ex;
        i_extent_y  <= b.ey;
        i_extent_z  <= b.ez;
        // Transfer happens at the first edge with busy low
        do @(posedge i_clk); while (busy);
        enqueue_outcome(apply_to_table(op, b));
        items_sent++;
        if (op == OP_QUERY)
            queries_sent++;
    endtask

    // Hold off until every outstanding result has been seen
    task automatic drain_results();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edges, touching and enclosing cameras, extremes, empty table, unused op
    task automatic test_directed();
        sender_idle_pct = 0;
        send_item(OP_QUERY, mk_box(0, 0, 0, 256, 256, 256));        // empty table
        send_item(OP_NOP,   mk_box(-1, -1, -1, 32767, 32767, 32767));
        send_item(OP_ADD,   mk_box(0, 0, 0, 256, 256, 256));
        send_item(OP_QUERY, mk_box(0, 0, 0, 256, 256, 256));        // identical box
        send_item(OP_QUERY, mk_box(0, 0, 0, 1024, 256, 1024));      // encloses on x, z
        send_item(OP_QUERY, mk_box(256, 0, 256, 256, 0, 256));      // low ends touch edge
        send_item(OP_QUERY, mk_box(257, 0, 0, 256, 0, 256));        // just past x edge
        send_item(OP_QUERY, mk_box(0, -128, 0, 0, 0, 0));           // y top on box bottom
        send_item(OP_QUERY, mk_box(0, -129, 0, 0, 0, 0));           // y just below
        send_item(OP_QUERY, mk_box(0, 512, 0, 0, 1024, 0));         // y encloses box
        send_item(OP_ADD,   mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_item(OP_ADD,   mk_box(-32768, -32768, -32768, 0, 0, 0));
        send_item(OP_QUERY, mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_item(OP_QUERY, mk_box(-32768, -32768, -32768, 0, 0, 0));
        send_item(OP_QUERY, mk_box(-32768, 32767, 32767, 32767, 32767, 32767));
        send_item(OP_CLEAR, mk_box(-1, -1, -1, 32767, 32767, 32767));
        send_item(OP_QUERY, mk_box(0, 0, 0, 256, 256, 256));        // table was cleared
        send_item(OP_ADD,   mk_box(-32768, 32767, -32768, 32767, 0, 32767));
        send_item(OP_QUERY, mk_box(-32768, 32767, -32768, 32767, 32767, 32767));
        send_item(OP_NOP,   mk_box(0, 0, 0, 0, 0, 0));
        send_item(OP_CLEAR, mk_box(0, 0, 0, 0, 0, 0));
    endtask

    // Fill the table, overflow it, then query a full table
    task automatic test_table_full();
        t_box_rec b;
        sender_idle_pct = 0;
        for (int i = 0; i < MAX_BOXES; i++)
            send_item(OP_ADD, random_box());
        for (int i = 0; i < 3; i++)
            send_item(OP_ADD, random_box());                          // dropped
        for (int i = 0; i < 3; i++) begin
            b = model_boxes[$urandom_range(MAX_BOXES - 1)];
            send_item(OP_QUERY, near_camera(b));
        end
        send_item(OP_QUERY, mk_box(0, 0, 0, 0, 0, 0));
        send_item(OP_CLEAR, random_box());
        send_item(OP_ADD, random_box());                              // accepted again
    endtask

    // Fill with some boxes and query them, with queries mixed in
    task automatic run_sequence(input int n_adds, input int n_queries);
        int r;
        t_box_rec cam;
        for (int i = 0; i < n_adds; i++) begin
            send_item(OP_ADD, random_box());
            if ($urandom_range(99) < 15)
                send_item(OP_QUERY, near_camera(model_boxes[$urandom_range(box_total - 1)]));
        end
        for (int i = 0; i < n_queries; i++) begin
            r = $urandom_range(99);
            if (box_total > 0 && r < 60)
                cam = near_camera(model_boxes[$urandom_range(box_total - 1)]);
            else if (box_total > 0 && r < 70)
                cam = enclosing_camera(model_boxes[$urandom_range(box_total - 1)]);
            else
                cam = random_box();
            send_item(OP_QUERY, cam);
        end
    endtask

    // Mostly well-formed fill/query/clear runs, some noise; rare full tables
    task automatic test_random(input int n_items, input int idle_pct);
        int target;
        int n_adds;
        sender_idle_pct = idle_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(11) == 0)
                n_adds = $urandom_range(60, 70);
            else
                n_adds = $urandom_range(1, 12);
            run_sequence(n_adds, $urandom_range(2, 12));
            repeat ($urandom_range(2))
                send_item(t_op'($urandom_range(3)), random_box());
            if ($urandom_range(9) < 8)
                send_item(OP_CLEAR, random_box());
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: results arrive in command order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with nothing pending: hit=%0b dropped=%0b", o_hit, o_dropped);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, o_hit);
                    mismatch_count++;
                end
                if (o_dropped !== want.dropped) begin
                    $error("dropped: expected %0b, got %0b", want.dropped, o_dropped);
                    mismatch_count++;
                end
            end
            if (o_hit === 1'b1)
                hits_seen++;
            if (o_dropped === 1'b1)
                drops_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any command or result transfer restarts the count
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_table_full();
        // Receiver cannot stall results, so only the sender idles
        test_random(450, 0);
        drain_results();
        test_random(450, 86);
        test_random(450, 30);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d results never arrived", pending_outcomes.size());
            mismatch_count++;
        end

        $display("Sent %0d commands (%0d queries): %0d hits, %0d dropped adds seen.",
                 items_sent, queries_sent, hits_seen, drops_seen);
        $display("Sender idle phases 0/86/30 percent, table filled to overflow several times.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/bct_pkg.sv
hdl/bct_match.sv
hdl/box_collision_table.sv
hdl/bct_checker.sv
tb/box_collision_table_tb.sv
